// File: rtl/khvrp_pkg.sv
// ----------------------------------------------------------------------------
// khvrp_pkg: shared definitions for the key/hex-value reply parser
// Widths, quantity codes, divisor classes and the beat carried between the
// parser front end and the scaling pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package khvrp_pkg;

    // Sizing of the parser state.
    localparam int KEY_CHARS    = 8;
    localparam int VALUE_DIGITS = 8;
    localparam int KEY_LEN_W    = $clog2(KEY_CHARS + 1);
    localparam int DIGIT_CNT_W  = $clog2(VALUE_DIGITS + 1);
    localparam int VALUE_W      = 4 * VALUE_DIGITS;

    // Port field widths.
    localparam int CHAR_W   = 8;
    localparam int QTY_W    = 3;
    localparam int RAW_W    = 32;
    localparam int SCALED_W = 40;
    localparam int HDR_W    = 8;

    localparam logic [HDR_W-1:0] HEADER_LENGTH_RESET = 8'd13;

    // Quantity codes; the code is also the row of the key name table.
    localparam int NUM_QTY = 7;
    localparam logic [QTY_W-1:0] Q_UDC = 3'd0;
    localparam logic [QTY_W-1:0] Q_IDC = 3'd1;
    localparam logic [QTY_W-1:0] Q_UL1 = 3'd2;
    localparam logic [QTY_W-1:0] Q_IL1 = 3'd3;
    localparam logic [QTY_W-1:0] Q_PAC = 3'd4;
    localparam logic [QTY_W-1:0] Q_TNF = 3'd5;
    localparam logic [QTY_W-1:0] Q_TKK = 3'd6;

    // Divisor classes of the scaled value.
    localparam logic [1:0] DIV_10  = 2'd0;
    localparam logic [1:0] DIV_100 = 2'd1;
    localparam logic [1:0] DIV_2   = 2'd2;
    localparam logic [1:0] DIV_1   = 2'd3;

    // One parsed result on its way to the scaler.
    typedef struct packed {
        logic             is_end;
        logic [QTY_W-1:0] quantity;
        logic [RAW_W-1:0] raw_value;
    } item_t;

    function automatic logic [1:0] qty_div(input logic [QTY_W-1:0] q);
        logic [1:0] cls;
        case (q)
            Q_UDC, Q_UL1:        cls = DIV_10;
            Q_IDC, Q_IL1, Q_TNF: cls = DIV_100;
            Q_PAC:               cls = DIV_2;
            default:             cls = DIV_1;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

// File: rtl/khvrp_if.sv
// ----------------------------------------------------------------------------
// khvrp_if: valid/ready channels of the reply parser
// The character channel feeds the parser, the result channel carries its
// measurement and end-of-payload beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface khvrp_char_if;
    logic                          valid;
    logic                          ready;
    logic [khvrp_pkg::CHAR_W-1:0]  char_byte;
    logic                          first;

    modport source (output valid, output char_byte, output first, input ready);
    modport sink   (input valid, input char_byte, input first, output ready);
endinterface

interface khvrp_result_if;
    logic                            valid;
    logic                            ready;
    logic                            is_end;
    logic [khvrp_pkg::QTY_W-1:0]     quantity;
    logic [khvrp_pkg::RAW_W-1:0]     raw_value;
    logic [khvrp_pkg::SCALED_W-1:0]  scaled_value;

    modport source (output valid, output is_end, output quantity, output raw_value,
                    output scaled_value, input ready);
    modport sink   (input valid, input is_end, input quantity, input raw_value,
                    input scaled_value, output ready);
endinterface

`default_nettype wire

// File: rtl/khvrp_scale.sv
// ----------------------------------------------------------------------------
// khvrp_scale: fixed-point scaling pipeline
// Two registered stages turn a raw hex value into raw * 256 / divisor,
// truncated, using a reciprocal multiply and a small remainder table.
// ----------------------------------------------------------------------------
`default_nettype none

module khvrp_scale (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  khvrp_pkg::item_t       item,
    output logic                   item_ready,
    khvrp_result_if.source         results
);

    localparam int QUOT_W = 30;
    localparam logic [31:0] MAGIC_DIV5  = 32'hCCCC_CCCD;
    localparam logic [31:0] MAGIC_DIV25 = 32'h51EB_851F;

    typedef logic [6:0] frac10_tab_t [8];
    typedef logic [5:0] frac100_tab_t [32];

    function automatic frac10_tab_t make_frac10();
        frac10_tab_t t;
        for (int i = 0; i < 8; i++)
        begin
            t[i] = 7'((i * 128) / 5);
        end
        return t;
    endfunction

    function automatic frac100_tab_t make_frac100();
        frac100_tab_t t;
        for (int i = 0; i < 32; i++)
        begin
            t[i] = 6'((i * 64) / 25);
        end
        return t;
    endfunction

    // Fraction bits of remainder / 5 and remainder / 25.
    localparam frac10_tab_t  FRAC10  = make_frac10();
    localparam frac100_tab_t FRAC100 = make_frac100();

    logic                            s2_valid_reg;
    logic                            s2_valid_next;
    khvrp_pkg::item_t                s2_item_reg;
    logic [1:0]                      s2_cls_reg;
    logic [QUOT_W-1:0]               s2_quot_reg;
    logic [QUOT_W-1:0]               quot_next;
    logic [63:0]                     product;
    logic [1:0]                      cls_in;
    logic                            s2_ready;

    logic                            o_valid_reg;
    logic                            o_valid_next;
    logic                            o_ready;
    logic                            o_is_end_reg;
    logic [khvrp_pkg::QTY_W-1:0]     o_quantity_reg;
    logic [khvrp_pkg::RAW_W-1:0]     o_raw_reg;
    logic [khvrp_pkg::SCALED_W-1:0]  o_scaled_reg;
    logic [khvrp_pkg::SCALED_W-1:0]  scaled_next;
    logic [31:0]                     quot_wide;
    logic [31:0]                     back_mult;
    logic [31:0]                     remainder;

    assign o_ready    = !o_valid_reg || results.ready;
    assign s2_ready   = !s2_valid_reg || o_ready;
    assign item_ready = s2_ready;

    // Stage 2: quotient by 5 or 25 through a reciprocal multiply.
    assign cls_in  = khvrp_pkg::qty_div(item.quantity);
    assign product = 64'(item.raw_value)
                   * 64'((cls_in == khvrp_pkg::DIV_100) ? MAGIC_DIV25 : MAGIC_DIV5);
    assign quot_next = (cls_in == khvrp_pkg::DIV_100) ? QUOT_W'(product[63:35])
                                                      : product[63:34];

    assign s2_valid_next = s2_ready ? item_valid : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && item_valid)
        begin
            s2_item_reg <= item;
            s2_cls_reg  <= cls_in;
            s2_quot_reg <= quot_next;
        end
    end

    // Output stage: remainder, fraction lookup and result assembly.
    always_comb
    begin
        quot_wide = 32'(s2_quot_reg);
        if (s2_cls_reg == khvrp_pkg::DIV_100)
        begin
            back_mult = (quot_wide << 4) + (quot_wide << 3) + quot_wide;
        end
        else
        begin
            back_mult = (quot_wide << 2) + quot_wide;
        end
        remainder = s2_item_reg.raw_value - back_mult;
        unique case (s2_cls_reg)
            khvrp_pkg::DIV_10:  scaled_next = {3'b0, s2_quot_reg, FRAC10[remainder[2:0]]};
            khvrp_pkg::DIV_100: scaled_next = {4'b0, s2_quot_reg, FRAC100[remainder[4:0]]};
            khvrp_pkg::DIV_2:   scaled_next = {1'b0, s2_item_reg.raw_value, 7'b0};
            khvrp_pkg::DIV_1:   scaled_next = {s2_item_reg.raw_value, 8'b0};
        endcase
    end

    assign o_valid_next = o_ready ? s2_valid_reg : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_ready && s2_valid_reg)
        begin
            o_is_end_reg   <= s2_item_reg.is_end;
            o_quantity_reg <= s2_item_reg.quantity;
            o_raw_reg      <= s2_item_reg.raw_value;
            o_scaled_reg   <= scaled_next;
        end
    end

    assign results.valid        = o_valid_reg;
    assign results.is_end       = o_is_end_reg;
    assign results.quantity     = o_quantity_reg;
    assign results.raw_value    = o_raw_reg;
    assign results.scaled_value = o_scaled_reg;

endmodule

`default_nettype wire

// File: rtl/key_hex_value_reply_parser_top.sv
// ----------------------------------------------------------------------------
// key_hex_value_reply_parser_top: device reply parser
// Skips a header, splits the payload into KEY=HEXVALUE; pairs, and emits a
// quantity code, the raw value and a Q32.8 scaled value per known key, plus
// an end beat at the '|' terminator.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Fields                                   | Notes
//  ----------+-----------+------------------------------------------+-----------------
//  chars     | sink      | char_byte[7:0], first                    | one char a beat
//  results   | source    | is_end, quantity[2:0], raw_value[31:0],  | 0 or 1 per char
//            |           | scaled_value[39:0]                       |
//  cfg_wr_*  | write     | cfg_wr_data[7:0] -> header_length        | no read-back
//
// One character is accepted every cycle while the result path has room.
// A result is offered from the output register once the character that
// produced it has passed the parse register and the multiply stage of the
// scaler. Backpressure ripples back through the three result registers, so
// chars.ready only drops when all of them are full and results is stalled.
// Reset is asynchronous and active low; it clears the parser state and sets
// header_length to 13.
// ----------------------------------------------------------------------------
`default_nettype none

module key_hex_value_reply_parser_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [khvrp_pkg::HDR_W-1:0]   cfg_wr_data,
    khvrp_char_if.sink                    chars,
    khvrp_result_if.source                results
);

    // Framing characters of the payload.
    localparam logic [7:0] CH_END  = 8'h7C;   // '|'
    localparam logic [7:0] CH_EQ   = 8'h3D;   // '='
    localparam logic [7:0] CH_SEMI = 8'h3B;   // ';'
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_LA   = 8'h61;
    localparam logic [7:0] CH_LF   = 8'h66;
    localparam logic [7:0] CH_UA   = 8'h41;
    localparam logic [7:0] CH_UF   = 8'h46;

    // Only the first three key characters can ever take part in a match;
    // longer keys are rejected through the length count.
    localparam int NAME_LEN = 3;
    localparam logic [23:0] KEY_NAMES [khvrp_pkg::NUM_QTY] =
        '{"UDC", "IDC", "UL1", "IL1", "PAC", "TNF", "TKK"};

    localparam int KLW = khvrp_pkg::KEY_LEN_W;
    localparam int DCW = khvrp_pkg::DIGIT_CNT_W;
    localparam int VW  = khvrp_pkg::VALUE_W;
    localparam logic [VW-1:0] VALUE_SAT = '1;

    // Configuration and parser state.
    logic [khvrp_pkg::HDR_W-1:0]  header_length_reg;
    logic [khvrp_pkg::HDR_W-1:0]  header_count_reg, header_count_next;
    logic                         in_value_reg, in_value_next;
    logic [7:0]                   key_reg [NAME_LEN];
    logic [7:0]                   key_next [NAME_LEN];
    logic [KLW-1:0]               key_len_reg, key_len_next;
    logic                         key_too_long_reg, key_too_long_next;
    logic [VW-1:0]                value_acc_reg, value_acc_next;
    logic [DCW-1:0]               value_digits_reg, value_digits_next;
    logic                         value_stopped_reg, value_stopped_next;
    logic                         payload_done_reg, payload_done_next;

    // Parse result register feeding the scaler.
    logic                         s1_valid_reg, s1_valid_next;
    khvrp_pkg::item_t             s1_item_reg, s1_item_next;
    logic                         s1_ready;
    logic                         scale_ready;

    logic                         accept;
    logic                         emit;
    logic [7:0]                   c;
    logic                         hex_ok;
    logic [3:0]                   hex_val;
    logic                         key_hit;
    logic [khvrp_pkg::QTY_W-1:0]  key_qty;

    assign c        = chars.char_byte;
    assign s1_ready = !s1_valid_reg || scale_ready;
    assign chars.ready = s1_ready;
    assign accept   = chars.valid && s1_ready;

    // Hex digit decode of the incoming character.
    always_comb
    begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            hex_val = 4'(c - CH_0);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            hex_val = 4'(c - CH_LA + 8'd10);
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            hex_val = 4'(c - CH_UA + 8'd10);
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    // Exact match of the stored key against the name table. The row that
    // hits is the quantity code.
    always_comb
    begin
        key_hit = 1'b0;
        key_qty = khvrp_pkg::Q_UDC;
        for (int i = 0; i < khvrp_pkg::NUM_QTY; i++)
        begin
            if ({key_reg[0], key_reg[1], key_reg[2]} == KEY_NAMES[i])
            begin
                key_hit = 1'b1;
                key_qty = khvrp_pkg::QTY_W'(i);
            end
        end
        if (key_too_long_reg || key_len_reg != KLW'(NAME_LEN))
        begin
            key_hit = 1'b0;
        end
    end

    // Next parser state for one accepted character. A character flagged as
    // first restarts the reply and is then handled as the first character of
    // the new reply. The branches below work on the _next values, which hold
    // the restarted state at that point, so with no header the first
    // character is already parsed as payload. The key match looks at the
    // registers, so it is masked on a restart, where the key is empty.
    always_comb
    begin
        header_count_next  = header_count_reg;
        in_value_next      = in_value_reg;
        key_next           = key_reg;
        key_len_next       = key_len_reg;
        key_too_long_next  = key_too_long_reg;
        value_acc_next     = value_acc_reg;
        value_digits_next  = value_digits_reg;
        value_stopped_next = value_stopped_reg;
        payload_done_next  = payload_done_reg;
        emit               = 1'b0;
        s1_item_next       = s1_item_reg;

        if (accept)
        begin
            if (chars.first)
            begin
                header_count_next  = '0;
                payload_done_next  = 1'b0;
                in_value_next      = 1'b0;
                key_next           = '{default: 8'h00};
                key_len_next       = '0;
                key_too_long_next  = 1'b0;
                value_acc_next     = '0;
                value_digits_next  = '0;
                value_stopped_next = 1'b0;
            end

            if (payload_done_next)
            begin
                // Everything after the terminator is dropped.
            end
            else if (header_count_next < header_length_reg)
            begin
                header_count_next = header_count_next + 8'd1;
            end
            else if (c == CH_END)
            begin
                payload_done_next      = 1'b1;
                emit                   = 1'b1;
                s1_item_next.is_end    = 1'b1;
                s1_item_next.quantity  = khvrp_pkg::Q_UDC;
                s1_item_next.raw_value = '0;
            end
            else if (c == CH_EQ)
            begin
                in_value_next = 1'b1;
            end
            else if (c == CH_SEMI)
            begin
                emit                   = key_hit && !chars.first;
                s1_item_next.is_end    = 1'b0;
                s1_item_next.quantity  = key_qty;
                s1_item_next.raw_value = khvrp_pkg::RAW_W'(value_acc_next);
                in_value_next          = 1'b0;
                key_next               = '{default: 8'h00};
                key_len_next           = '0;
                key_too_long_next      = 1'b0;
                value_acc_next         = '0;
                value_digits_next      = '0;
                value_stopped_next     = 1'b0;
            end
            else if (!in_value_next)
            begin
                if (key_len_next < KLW'(khvrp_pkg::KEY_CHARS))
                begin
                    if (key_len_next < KLW'(NAME_LEN))
                    begin
                        key_next[key_len_next[1:0]] = c;
                    end
                    key_len_next = key_len_next + KLW'(1);
                end
                else
                begin
                    key_too_long_next = 1'b1;
                end
            end
            else if (!value_stopped_next)
            begin
                // Leading zeros are not counted; a significant digit past the
                // limit saturates the value.
                if (!hex_ok)
                begin
                    value_stopped_next = 1'b1;
                end
                else if (value_acc_next == '0 && hex_val == 4'd0)
                begin
                    // A leading zero leaves the value at zero.
                end
                else if (value_digits_next >= DCW'(khvrp_pkg::VALUE_DIGITS))
                begin
                    value_acc_next = VALUE_SAT;
                end
                else
                begin
                    value_acc_next    = {value_acc_next[VW-5:0], hex_val};
                    value_digits_next = value_digits_next + DCW'(1);
                end
            end
        end
    end

    // The parse register accepts a new result whenever it is empty or being
    // drained; a character is only accepted under that same condition.
    assign s1_valid_next = s1_ready ? emit : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_length_reg <= khvrp_pkg::HEADER_LENGTH_RESET;
            header_count_reg  <= '0;
            in_value_reg      <= 1'b0;
            key_reg           <= '{default: 8'h00};
            key_len_reg       <= '0;
            key_too_long_reg  <= 1'b0;
            value_acc_reg     <= '0;
            value_digits_reg  <= '0;
            value_stopped_reg <= 1'b0;
            payload_done_reg  <= 1'b0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                header_length_reg <= cfg_wr_data;
            end
            header_count_reg  <= header_count_next;
            in_value_reg      <= in_value_next;
            key_reg           <= key_next;
            key_len_reg       <= key_len_next;
            key_too_long_reg  <= key_too_long_next;
            value_acc_reg     <= value_acc_next;
            value_digits_reg  <= value_digits_next;
            value_stopped_reg <= value_stopped_next;
            payload_done_reg  <= payload_done_next;
            s1_valid_reg      <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    // Divides the raw value by the quantity's divisor in Q32.8 and drives
    // the result channel from its output register.
    khvrp_scale u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (s1_valid_reg),
        .item       (s1_item_reg),
        .item_ready (scale_ready),
        .results    (results)
    );

endmodule

`default_nettype wire

// File: rtl/khvrp_checker.sv
// ----------------------------------------------------------------------------
// khvrp_checker: port-level checks of the reply parser
// Watches the result channel for reset behavior, stall holding, zero end beats
// and the exact scaling of the divide-by-one and divide-by-two quantities.
// ----------------------------------------------------------------------------
`default_nettype none

module khvrp_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              valid,
    input  logic                              ready,
    input  logic                              is_end,
    input  logic [khvrp_pkg::QTY_W-1:0]       quantity,
    input  logic [khvrp_pkg::RAW_W-1:0]       raw_value,
    input  logic [khvrp_pkg::SCALED_W-1:0]    scaled_value
);

    // Checked in the following cycle, once the reset has surely cleared the output.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !valid)
        else $error("result beat offered during reset");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(is_end) && $stable(quantity)
                            && $stable(raw_value) && $stable(scaled_value))
        else $error("stalled result beat changed");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && is_end |-> quantity == khvrp_pkg::Q_UDC && raw_value == '0
                            && scaled_value == '0)
        else $error("end beat carries a nonzero payload");

    a_tkk_scale: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !is_end && quantity == khvrp_pkg::Q_TKK
            |-> scaled_value == {raw_value, 8'h00})
        else $error("temperature value not scaled by 256");

    a_pac_scale: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !is_end && quantity == khvrp_pkg::Q_PAC
            |-> scaled_value == {1'b0, raw_value, 7'h00})
        else $error("power value not scaled by 128");

endmodule

bind key_hex_value_reply_parser_top khvrp_checker u_khvrp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (results.valid),
    .ready        (results.ready),
    .is_end       (results.is_end),
    .quantity     (results.quantity),
    .raw_value    (results.raw_value),
    .scaled_value (results.scaled_value)
);

`default_nettype wire

// File: sim/khvrp_reading_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// khvrp_reading_check: predicts and checks the reply parser's result beats
// Follows every accepted character and register write with its own model of
// the parser and compares each result beat, field by field, with the oldest
// expected reading.
// ----------------------------------------------------------------------------
module khvrp_reading_check
    import khvrp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [HDR_W-1:0] cfg_wr_data,
    khvrp_char_if            chars,
    khvrp_result_if          results,
    output int               fail_count,
    output int               results_waiting
);

    localparam logic [CHAR_W-1:0] END_MARK = "|";
    localparam logic [CHAR_W-1:0] KV_SEP   = "=";
    localparam logic [CHAR_W-1:0] PAIR_SEP = ";";
    localparam logic [RAW_W-1:0]  RAW_SAT  = {RAW_W{1'b1}} >> (RAW_W - VALUE_W);

    typedef struct packed {
        logic                is_end;
        logic [QTY_W-1:0]    quantity;
        logic [RAW_W-1:0]    raw_value;
        logic [SCALED_W-1:0] scaled_value;
    } reading_t;

    reading_t          due_q[$];
    logic [HDR_W-1:0]  header_len;
    logic [HDR_W-1:0]  header_seen;
    logic              in_value;
    logic              key_overflow;
    logic              value_stopped;
    logic              payload_done;
    logic [CHAR_W-1:0] key_buf [KEY_CHARS];
    int                key_cnt;
    int                digit_cnt;
    logic [RAW_W-1:0]  value_acc;
    int                errs = 0;

    task automatic report(input string msg);
        $display("%0t ERROR %s", $time, msg);
        errs++;
    endtask

    task automatic drop_pair();
        in_value      = 1'b0;
        key_overflow  = 1'b0;
        value_stopped = 1'b0;
        key_cnt       = 0;
        digit_cnt     = 0;
        value_acc     = '0;
        foreach (key_buf[i])
            key_buf[i] = '0;
    endtask

    task automatic restart_reply();
        header_seen  = '0;
        payload_done = 1'b0;
        drop_pair();
    endtask

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
        if (c >= "0" && c <= "9")
            return {1'b1, 4'(c - "0")};
        if (c >= "a" && c <= "f")
            return {1'b1, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F")
            return {1'b1, 4'(c - "A" + 8'd10)};
        return 5'd0;
    endfunction

    function automatic logic known_key(output logic [QTY_W-1:0] q);
        q = '0;
        if (key_overflow || key_cnt != 3)
            return 1'b0;
        case ({key_buf[0], key_buf[1], key_buf[2]})
            "UDC":   q = Q_UDC;
            "IDC":   q = Q_IDC;
            "UL1":   q = Q_UL1;
            "IL1":   q = Q_IL1;
            "PAC":   q = Q_PAC;
            "TNF":   q = Q_TNF;
            "TKK":   q = Q_TKK;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Q32.8 result of the raw value over the quantity's divisor, truncated.
    function automatic logic [SCALED_W-1:0] scale_raw(input logic [QTY_W-1:0] q,
                                                      input logic [RAW_W-1:0] raw);
        logic [SCALED_W-1:0] shifted;
        logic [SCALED_W-1:0] divisor;
        shifted = {raw, 8'h00};
        case (q)
            Q_UDC, Q_UL1:        divisor = 40'd10;
            Q_IDC, Q_IL1, Q_TNF: divisor = 40'd100;
            Q_PAC:               divisor = 40'd2;
            default:             divisor = 40'd1;
        endcase
        return shifted / divisor;
    endfunction

    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic first_char);
        logic [QTY_W-1:0] q;
        logic [4:0]       d;
        if (first_char)
            restart_reply();
        if (payload_done)
            return;
        if (header_seen < header_len)
        begin
            header_seen++;
            return;
        end
        if (c == END_MARK)
        begin
            payload_done = 1'b1;
            due_q.push_back('{1'b1, '0, '0, '0});
        end
        else if (c == KV_SEP)
            in_value = 1'b1;
        else if (c == PAIR_SEP)
        begin
            if (known_key(q))
                due_q.push_back('{1'b0, q, value_acc, scale_raw(q, value_acc)});
            drop_pair();
        end
        else if (!in_value)
        begin
            if (key_cnt < KEY_CHARS)
            begin
                key_buf[key_cnt] = c;
                key_cnt++;
            end
            else
                key_overflow = 1'b1;
        end
        else if (!value_stopped)
        begin
            d = hex_digit(c);
            if (!d[4])
                value_stopped = 1'b1;
            else if (value_acc != 0 || d[3:0] != 0)
            begin
                if (digit_cnt >= VALUE_DIGITS)
                    value_acc = RAW_SAT;
                else
                begin
                    value_acc = {value_acc[RAW_W-5:0], d[3:0]};
                    digit_cnt++;
                end
            end
        end
    endtask

    task automatic check_reading();
        reading_t want;
        if (due_q.size() == 0)
        begin
            report($sformatf("result with none due: is_end %0d quantity %0d raw %0h",
                             results.is_end, results.quantity, results.raw_value));
            return;
        end
        want = due_q.pop_front();
        if (results.is_end !== want.is_end)
            report($sformatf("is_end expected %0d got %0d", want.is_end, results.is_end));
        if (results.quantity !== want.quantity)
            report($sformatf("quantity expected %0d got %0d",
                             want.quantity, results.quantity));
        if (results.raw_value !== want.raw_value)
            report($sformatf("raw_value expected %0h got %0h",
                             want.raw_value, results.raw_value));
        if (results.scaled_value !== want.scaled_value)
            report($sformatf("scaled_value expected %0h got %0h",
                             want.scaled_value, results.scaled_value));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_len = HEADER_LENGTH_RESET;
            restart_reply();
            due_q.delete();
            fail_count      <= 0;
            results_waiting <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
                check_reading();
            if (cfg_wr_en)
                header_len = cfg_wr_data;
            if (chars.valid && chars.ready)
                parse_char(chars.char_byte, chars.first);
            fail_count      <= errs;
            results_waiting <= due_q.size();
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the key/hex-value reply parser
// Sends device replies one character per beat, first a few hand-written ones
// and then random replies under several header lengths, with random gaps on
// the character channel and random stalls on the result channel. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;

    import khvrp_pkg::*;

    // Cycles with no accepted beat on either channel before the run is ended.
    localparam int QUIET_LIMIT = 2000;
    // Cycles the result side is held off once, to fill the block up.
    localparam int HOLD_CYCLES = 300;
    // Cycles allowed after the last expected result for the pipeline to empty.
    localparam int SETTLE      = 8;
    localparam int ITEM_GOAL   = 750;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_SLOW, SINK_CYCLIC} sink_mode_e;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [HDR_W-1:0] cfg_wr_data;
    int               fail_count;
    int               results_waiting;

    khvrp_char_if   chars ();
    khvrp_result_if results ();

    key_hex_value_reply_parser_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .chars       (chars),
        .results     (results)
    );

    khvrp_reading_check reading_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .chars           (chars),
        .results         (results),
        .fail_count      (fail_count),
        .results_waiting (results_waiting)
    );

    // The reply being sent, one character per entry.
    logic [7:0] msg[$];
    string      qty_names[7] = '{"UDC", "IDC", "UL1", "IL1", "PAC", "TNF", "TKK"};
    int         hdr_len      = 13;
    int         burst_left   = 0;
    bit         hold_req     = 1'b0;
    int         quiet        = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Reply building
    // ------------------------------------------------------------------------

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            msg.push_back(s[i]);
    endtask

    // Any byte except the three that steer the parser.
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == "=" || c == ";" || c == "|");
        return c;
    endfunction

    // A plain byte that also is no hex digit, so it stops a value.
    function automatic logic [7:0] stop_char();
        logic [7:0] c;
        do
            c = plain_char();
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
        return c;
    endfunction

    function automatic logic [7:0] hex_char();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10)
            return 8'("0" + d);
        return $urandom_range(0, 1) ? 8'("a" + d - 10) : 8'("A" + d - 10);
    endfunction

    // Leading zeros now and then, mostly up to eight significant digits, a
    // few values too long to fit, and sometimes a stray character followed
    // by more digits that must be ignored.
    task automatic add_value();
        int r;
        int ndig;
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) add_str("0");
        r = $urandom_range(0, 19);
        if (r == 0)
            ndig = 0;
        else if (r <= 2)
            ndig = $urandom_range(9, 11);
        else
            ndig = $urandom_range(1, 8);
        repeat (ndig) msg.push_back(hex_char());
        if ($urandom_range(0, 9) == 0)
        begin
            msg.push_back(stop_char());
            repeat ($urandom_range(0, 3)) msg.push_back(hex_char());
        end
    endtask

    // Mostly a known key; otherwise a key that must not match: wrong case,
    // one character too many, three random bytes, up to twelve random bytes or empty.
    task automatic add_key();
        string name;
        name = qty_names[$urandom_range(0, 6)];
        if ($urandom_range(0, 99) < 80)
            add_str(name);
        else
            case ($urandom_range(0, 4))
                0: add_str(name.tolower());
                1:
                begin
                    add_str(name);
                    msg.push_back(plain_char());
                end
                2: repeat (3) msg.push_back(plain_char());
                3: repeat ($urandom_range(1, 12)) msg.push_back(plain_char());
                default: ;
            endcase
    endtask

    task automatic add_pair();
        add_key();
        if ($urandom_range(0, 9) != 0)
        begin
            add_str("=");
            if ($urandom_range(0, 14) == 0)
                add_str("=");
            add_value();
        end
        add_str(";");
    endtask

    // One reply: random header bytes, some pairs, perhaps a pair left open,
    // the end mark and a little trailing noise. Now and then the reply is cut
    // short, which gives short replies and restarts in the middle of a
    // payload. The count of characters the parser actually works on is
    // returned, trailing noise left out.
    task automatic build_reply(input int hlen, output int useful);
        int cut;
        msg.delete();
        repeat (hlen) msg.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 6)) add_pair();
        if ($urandom_range(0, 9) == 0)
        begin
            add_key();
            add_str("=");
            add_value();
        end
        add_str("|");
        useful = msg.size();
        repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 14) == 0)
        begin
            cut = $urandom_range(1, msg.size());
            msg = msg[0:cut-1];
            if (cut < useful)
                useful = cut;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------

    // Offers one beat and returns right after the edge that took it. The
    // sender works in bursts; a gap of random length may open before a new
    // burst, and valid stays high from beat to beat inside a burst.
    task automatic send_beat(input logic [7:0] c, input logic is_first);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 48);
            if (gap != 0)
            begin
                chars.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        chars.valid     <= 1'b1;
        chars.char_byte <= c;
        chars.first     <= is_first;
        @(posedge clk);
        while (!chars.ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic send_msg();
        foreach (msg[i])
            send_beat(msg[i], i == 0);
    endtask

    // Stops sending and waits until every expected result has come out. The
    // first edge lets the checker count the beat accepted last; the settle
    // cycles cover characters that are still in the pipeline without a result.
    task automatic drain();
        chars.valid <= 1'b0;
        @(posedge clk);
        while (results_waiting != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Only called while the block is idle.
    task automatic set_header_len(input int v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= HDR_W'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        hdr_len = v;
    endtask

    // ------------------------------------------------------------------------
    // Result side: stalls in a mode that changes now and then, and holds off
    // for a long stretch once when asked to.
    // ------------------------------------------------------------------------
    initial
    begin
        sink_mode_e mode;
        int         mode_left;
        int         tick;
        mode          = SINK_OPEN;
        mode_left     = 0;
        tick          = 0;
        results.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                results.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = sink_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            case (mode)
                SINK_OPEN: results.ready <= 1'b1;
                SINK_COIN: results.ready <= 1'($urandom_range(0, 1));
                SINK_SLOW: results.ready <= ($urandom_range(0, 4) == 0);
                default:   results.ready <= (tick % 5) < 2;
            endcase
            mode_left--;
            tick++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if nothing moves on either channel for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((chars.valid && chars.ready) || (results.valid && results.ready))
                quiet <= 0;
            else if (quiet == QUIET_LIMIT)
            begin
                $display("key_hex_value_reply_parser_top test failed");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        int useful;
        int phase_items;
        int total_items;
        int phase;
        chars.valid     = 1'b0;
        chars.char_byte = '0;
        chars.first     = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        rst_n           = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header length still at its reset value: the header holds the
        // extreme bytes, and the value has leading zeros and more significant
        // digits than fit, so it saturates.
        msg.delete();
        msg.push_back(8'h00);
        msg.push_back(8'hFF);
        repeat (11) msg.push_back(8'($urandom_range(0, 255)));
        add_str("TKK=00123456789;|");
        send_msg();
        drain();

        // No header at all. Largest raw value, a key without '=', a key with
        // the extreme bytes that matches nothing, a doubled '=' with a value
        // stopped by a sign, a lower-case name, a pair left open at the end
        // mark and a pair after it that must be ignored.
        set_header_len(0);
        msg.delete();
        add_str("IDC=FFFFFFFF;UL1;X");
        msg.push_back(8'h00);
        msg.push_back(8'hFF);
        add_str("=5;PAC==a-7;udc=3;IL1=4|TNF=1;");
        send_msg();
        // A reply broken off mid pair by the start of a new one.
        msg.delete();
        add_str("UDC=2");
        send_msg();
        msg.delete();
        add_str("TNF=1F;|");
        send_msg();
        drain();

        // Random replies, one header length per phase, drained between them.
        total_items = 0;
        phase       = 0;
        while (total_items < ITEM_GOAL)
        begin
            case (phase)
                0:       set_header_len(13);
                1:       set_header_len(1);
                2:       set_header_len(255);
                3:       set_header_len(0);
                4:       set_header_len(2);
                default: set_header_len($urandom_range(0, 24));
            endcase
            // Short headers give many results, so the long hold-off lands
            // here and the block fills up while the sender keeps offering.
            if (phase == 1)
                hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < 130)
            begin
                build_reply(hdr_len, useful);
                send_msg();
                phase_items += useful;
            end
            total_items += phase_items;
            drain();
            phase++;
        end

        if (fail_count == 0 && results_waiting == 0)
            $display("key_hex_value_reply_parser_top test passed");
        else
            $display("key_hex_value_reply_parser_top test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/khvrp_pkg.sv
rtl/khvrp_if.sv
rtl/khvrp_scale.sv
rtl/key_hex_value_reply_parser_top.sv
rtl/khvrp_checker.sv
sim/khvrp_reading_check.sv
sim/tb.sv
